/* rtl/bis_pkg.sv */
// bis_pkg: shared types and constants of the bilinear image scaler
// used by bis_div, bis_ctrl, bis_dp and bilinear_image_scaler
package bis_pkg;

  // item field widths
  localparam int unsigned SRC_W    = 9;
  localparam int unsigned DST_W    = 12;
  localparam int unsigned LADDR_W  = 16;
  localparam int unsigned PIXIN_W  = 32;
  localparam int unsigned PIX_W    = 24;
  localparam int unsigned STEP_W   = 24;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned POS_W    = STEP_W + DST_W;
  localparam int unsigned INT_W    = POS_W - FRAC_W;
  localparam int unsigned CALC_W   = 32;
  localparam int unsigned WGT_W    = 17;
  localparam int unsigned ACC_W    = 25;

  // step divider
  localparam int unsigned NUM_W    = SRC_W + FRAC_W;
  localparam int unsigned DCNT_W   = 5;

  // configuration port
  localparam int unsigned PADDR_W  = 5;
  localparam int unsigned PDATA_W  = 32;

  localparam int unsigned STORE_DEPTH_DEF = 65536;

  localparam logic [SRC_W-1:0] SRC_RST = SRC_W'(256);
  localparam logic [DST_W-1:0] DST_RST = DST_W'(1);

  // request kinds
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  // register indexes
  typedef enum logic [2:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_SRC_STRIDE = 3'd2,
    REG_DST_WIDTH  = 3'd3,
    REG_DST_HEIGHT = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_BASE,
    S_RD,
    S_LAST,
    S_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic       mem_we;
    logic       capture;
    logic       mul_en;
    logic       base_en;
    logic       rd_issue;
    logic [1:0] nb;
    logic       out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic busy;
    logic in_range;
  } status_t;

endpackage

/* rtl/bilinear_image_scaler.sv */
// bilinear_image_scaler: top level with the configuration registers
// depends on bis_pkg, bis_ctrl, bis_dp
//
//  channel  signals                                  direction
//  in       in_valid_i/in_ready_o, req_type_i ...    item into the block
//  out      out_valid_o/out_ready_i, pixel_out_o ... item out of the block
//  cfg      psel, penable, pwrite, paddr, pwdata ... register access
//
// a load item is written to the frame store as it is accepted. a pixel item goes
// from S_MUL via S_BASE, four reads of the single-port frame store and S_LAST
// (out of range: directly) to S_DONE, which loads the result register and returns
// to S_IDLE for the next item. a write to one of the five registers blocks items
// while the two step dividers run. reset clears the steps to zero; the store has
// no clearing pass. a waiting result holds a pixel item in S_DONE, and the input.
module bilinear_image_scaler #(
  parameter int unsigned STORE_DEPTH = bis_pkg::STORE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bis_pkg::PADDR_W-1:0]   paddr,
  input  logic [bis_pkg::PDATA_W-1:0]   pwdata,
  output logic [bis_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic [bis_pkg::LADDR_W-1:0]   load_address_i,
  input  logic [bis_pkg::PIXIN_W-1:0]   pixel_value_i,
  input  logic [bis_pkg::DST_W-1:0]     out_x_i,
  input  logic [bis_pkg::DST_W-1:0]     out_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bis_pkg::PIX_W-1:0]     pixel_out_o,
  output logic                          out_of_range_o
);

  logic [bis_pkg::SRC_W-1:0] src_width_q, src_height_q, src_stride_q;
  logic [bis_pkg::DST_W-1:0] dst_width_q, dst_height_q;
  logic                      recompute_q;
  logic                      cfg_wr;
  logic [2:0]                cfg_idx;
  bis_pkg::cmd_t             cmd;
  bis_pkg::status_t          status;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[bis_pkg::PADDR_W-1:2];

  // register writes and step recompute request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= bis_pkg::SRC_RST;
      src_height_q <= bis_pkg::SRC_RST;
      src_stride_q <= bis_pkg::SRC_RST;
      dst_width_q  <= bis_pkg::DST_RST;
      dst_height_q <= bis_pkg::DST_RST;
      recompute_q  <= 1'b0;
    end else begin
      recompute_q <= 1'b0;
      if (cfg_wr) begin
        unique case (cfg_idx)
          bis_pkg::REG_SRC_WIDTH:  begin
            src_width_q <= pwdata[bis_pkg::SRC_W-1:0];  recompute_q <= 1'b1;
          end
          bis_pkg::REG_SRC_HEIGHT: begin
            src_height_q <= pwdata[bis_pkg::SRC_W-1:0]; recompute_q <= 1'b1;
          end
          bis_pkg::REG_SRC_STRIDE: begin
            src_stride_q <= pwdata[bis_pkg::SRC_W-1:0]; recompute_q <= 1'b1;
          end
          bis_pkg::REG_DST_WIDTH:  begin
            dst_width_q <= pwdata[bis_pkg::DST_W-1:0];  recompute_q <= 1'b1;
          end
          bis_pkg::REG_DST_HEIGHT: begin
            dst_height_q <= pwdata[bis_pkg::DST_W-1:0]; recompute_q <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // register read
  always_comb begin
    unique case (cfg_idx)
      bis_pkg::REG_SRC_WIDTH:  prdata = bis_pkg::PDATA_W'(src_width_q);
      bis_pkg::REG_SRC_HEIGHT: prdata = bis_pkg::PDATA_W'(src_height_q);
      bis_pkg::REG_SRC_STRIDE: prdata = bis_pkg::PDATA_W'(src_stride_q);
      bis_pkg::REG_DST_WIDTH:  prdata = bis_pkg::PDATA_W'(dst_width_q);
      bis_pkg::REG_DST_HEIGHT: prdata = bis_pkg::PDATA_W'(dst_height_q);
      default:                 prdata = '0;
    endcase
  end

  bis_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bis_dp #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .recompute_i    (recompute_q),
    .src_width_i    (src_width_q),
    .src_height_i   (src_height_q),
    .src_stride_i   (src_stride_q),
    .dst_width_i    (dst_width_q),
    .dst_height_i   (dst_height_q),
    .load_address_i (load_address_i),
    .pixel_value_i  (pixel_value_i),
    .out_x_i        (out_x_i),
    .out_y_i        (out_y_i),
    .pixel_out_o    (pixel_out_o),
    .out_of_range_o (out_of_range_o)
  );

  // no item taken while the steps are recomputed
  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.busy |-> !in_ready_o) else $error("item taken during step recompute");

  // a write to one of the five registers holds off items in the next cycle
  a_cfg_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && cfg_idx <= bis_pkg::REG_DST_HEIGHT) |=> !in_ready_o)
    else $error("item taken after write");

  // a pixel item is worked on alone
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && req_type_i == bis_pkg::REQ_PIXEL) |=> !in_ready_o)
    else $error("second item taken during a pixel item");

  // an out-of-range result carries a zero pixel
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_of_range_o) |-> pixel_out_o == '0)
    else $error("out-of-range result with non-zero pixel");

endmodule

/* rtl/bis_div.sv */
// bis_div: restoring divider, one quotient bit per cycle, saturating result
// depends on bis_pkg
module bis_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [bis_pkg::NUM_W-1:0]     num_i,
  input  logic [bis_pkg::DST_W-1:0]     den_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [bis_pkg::STEP_W-1:0]    quo_o
);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [bis_pkg::DCNT_W-1:0]  cnt_q, cnt_d;
  logic [bis_pkg::NUM_W-1:0]   num_q, num_d;
  logic [bis_pkg::DST_W-1:0]   rem_q, rem_d;
  logic [bis_pkg::DST_W-1:0]   den_q, den_d;
  logic [bis_pkg::DST_W:0]     trial;
  logic                        ge;

  // one shift and subtract step
  always_comb begin
    trial  = {rem_q, num_q[bis_pkg::NUM_W-1]};
    ge     = trial >= {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      num_d = {num_q[bis_pkg::NUM_W-2:0], ge};
      rem_d = ge ? bis_pkg::DST_W'(trial - {1'b0, den_q})
                 : trial[bis_pkg::DST_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == bis_pkg::DCNT_W'(bis_pkg::NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  // saturate to the step width
  assign quo_o  = (num_q[bis_pkg::NUM_W-1:bis_pkg::STEP_W] != '0) ? '1
                : num_q[bis_pkg::STEP_W-1:0];
  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

/* rtl/bis_ctrl.sv */
// bis_ctrl: sequencer for load and pixel items and the result register handshake
// depends on bis_pkg
module bis_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  bis_pkg::status_t   status_i,
  output bis_pkg::cmd_t      cmd_o
);

  bis_pkg::state_e state_q, state_d;
  logic [1:0]      nb_q, nb_d;
  logic            out_valid_q, out_valid_d;
  logic            accept;
  logic            out_free;

  assign in_ready_o = (state_q == bis_pkg::S_IDLE) && !status_i.busy;
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    nb_d    = nb_q;
    unique case (state_q)
      bis_pkg::S_IDLE: begin
        if (accept && req_type_i == bis_pkg::REQ_PIXEL) state_d = bis_pkg::S_MUL;
      end
      bis_pkg::S_MUL: begin
        state_d = status_i.in_range ? bis_pkg::S_BASE : bis_pkg::S_DONE;
      end
      bis_pkg::S_BASE: begin
        state_d = bis_pkg::S_RD;
        nb_d    = '0;
      end
      bis_pkg::S_RD: begin
        nb_d = nb_q + 1'b1;
        if (nb_q == 2'd3) state_d = bis_pkg::S_LAST;
      end
      bis_pkg::S_LAST: begin
        state_d = bis_pkg::S_DONE;
      end
      bis_pkg::S_DONE: begin
        if (out_free) state_d = bis_pkg::S_IDLE;
      end
      default: state_d = bis_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = accept;
    cmd_o.mem_we   = accept && req_type_i == bis_pkg::REQ_LOAD;
    cmd_o.mul_en   = state_q == bis_pkg::S_MUL;
    cmd_o.base_en  = state_q == bis_pkg::S_BASE;
    cmd_o.rd_issue = state_q == bis_pkg::S_RD;
    cmd_o.nb       = nb_q;
    cmd_o.out_load = state_q == bis_pkg::S_DONE && out_free;
  end

  // result register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bis_pkg::S_IDLE;
      nb_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nb_q        <= nb_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/bis_dp.sv */
// bis_dp: frame store, step dividers, position arithmetic and blend accumulators
// depends on bis_pkg and bis_div
module bis_dp #(
  parameter int unsigned STORE_DEPTH = bis_pkg::STORE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bis_pkg::cmd_t                 cmd_i,
  output bis_pkg::status_t              status_o,
  input  logic                          recompute_i,
  input  logic [bis_pkg::SRC_W-1:0]     src_width_i,
  input  logic [bis_pkg::SRC_W-1:0]     src_height_i,
  input  logic [bis_pkg::SRC_W-1:0]     src_stride_i,
  input  logic [bis_pkg::DST_W-1:0]     dst_width_i,
  input  logic [bis_pkg::DST_W-1:0]     dst_height_i,
  input  logic [bis_pkg::LADDR_W-1:0]   load_address_i,
  input  logic [bis_pkg::PIXIN_W-1:0]   pixel_value_i,
  input  logic [bis_pkg::DST_W-1:0]     out_x_i,
  input  logic [bis_pkg::DST_W-1:0]     out_y_i,
  output logic [bis_pkg::PIX_W-1:0]     pixel_out_o,
  output logic                          out_of_range_o
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);

  logic [bis_pkg::PIX_W-1:0]   mem_q [STORE_DEPTH];

  logic [bis_pkg::DST_W-1:0]   eff_dw, eff_dh;
  logic [bis_pkg::NUM_W-1:0]   num_x, num_y;
  logic                        xbusy, ybusy, xdone, ydone;
  logic [bis_pkg::STEP_W-1:0]  xquo, yquo;
  logic [bis_pkg::STEP_W-1:0]  x_step_q, y_step_q;

  logic [bis_pkg::DST_W-1:0]   ox_q, oy_q;
  logic [bis_pkg::POS_W-1:0]   px_q, py_q;
  logic                        oor_q;
  logic [bis_pkg::CALC_W-1:0]  base_q;
  logic [7:0]                  fx_q, fy_q;

  logic [bis_pkg::CALC_W-1:0]  ld_addr, rd_addr;
  logic                        rd_oob;
  logic [8:0]                  gx, gy;
  logic [17:0]                 wprod;
  logic [bis_pkg::PIX_W-1:0]   rdata_q, pix;
  logic                        rd_vld_q, rd_oob_q;
  logic [bis_pkg::WGT_W-1:0]   w_q;
  logic [bis_pkg::ACC_W-1:0]   acc_q [3];

  logic [bis_pkg::PIX_W-1:0]   pix_out_q;
  logic                        oor_out_q;

  // effective sizes and step dividends
  assign eff_dw = (dst_width_i  == '0) ? bis_pkg::DST_W'(1) : dst_width_i;
  assign eff_dh = (dst_height_i == '0) ? bis_pkg::DST_W'(1) : dst_height_i;
  assign num_x  = {((src_width_i  == '0) ? '0 : src_width_i  - 1'b1),
                   bis_pkg::FRAC_W'(0)};
  assign num_y  = {((src_height_i == '0) ? '0 : src_height_i - 1'b1),
                   bis_pkg::FRAC_W'(0)};

  bis_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (recompute_i),
    .num_i   (num_x),
    .den_i   (eff_dw),
    .busy_o  (xbusy),
    .done_o  (xdone),
    .quo_o   (xquo)
  );

  bis_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (recompute_i),
    .num_i   (num_y),
    .den_i   (eff_dh),
    .busy_o  (ybusy),
    .done_o  (ydone),
    .quo_o   (yquo)
  );

  // step registers, zero until the first step recompute after reset is done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_step_q <= '0;
      y_step_q <= '0;
    end else begin
      if (xdone) x_step_q <= xquo;
      if (ydone) y_step_q <= yquo;
    end
  end

  assign status_o.busy     = recompute_i || xbusy || ybusy || xdone || ydone;
  assign status_o.in_range = (ox_q < eff_dw) && (oy_q < eff_dh);

  // weights of the neighbour being read
  always_comb begin
    gx    = cmd_i.nb[0] ? {1'b0, fx_q} : 9'd256 - {1'b0, fx_q};
    gy    = cmd_i.nb[1] ? {1'b0, fy_q} : 9'd256 - {1'b0, fy_q};
    wprod = gx * gy;
  end

  // neighbour address and bounds
  assign ld_addr = bis_pkg::CALC_W'(load_address_i);
  assign rd_addr = base_q + (cmd_i.nb[1] ? bis_pkg::CALC_W'(src_stride_i) : '0)
                 + bis_pkg::CALC_W'(cmd_i.nb[0]);
  assign rd_oob  = rd_addr >= bis_pkg::CALC_W'(STORE_DEPTH);

  // single-port frame store
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      if (ld_addr < bis_pkg::CALC_W'(STORE_DEPTH))
        mem_q[ld_addr[AW-1:0]] <= pixel_value_i[bis_pkg::PIX_W-1:0];
    end else if (cmd_i.rd_issue) begin
      rdata_q <= mem_q[rd_addr[AW-1:0]];
    end
  end

  // item capture, position, base address, weights
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ox_q <= out_x_i;
      oy_q <= out_y_i;
    end
    if (cmd_i.mul_en) begin
      px_q  <= bis_pkg::POS_W'(x_step_q * ox_q);
      py_q  <= bis_pkg::POS_W'(y_step_q * oy_q);
      oor_q <= !status_o.in_range;
    end
    if (cmd_i.base_en) begin
      base_q <= bis_pkg::CALC_W'(bis_pkg::CALC_W'(py_q[bis_pkg::POS_W-1:bis_pkg::FRAC_W])
                                 * bis_pkg::CALC_W'(src_stride_i))
              + bis_pkg::CALC_W'(px_q[bis_pkg::POS_W-1:bis_pkg::FRAC_W]);
      fx_q   <= px_q[15:8];
      fy_q   <= py_q[15:8];
    end
    if (cmd_i.rd_issue) begin
      w_q      <= wprod[bis_pkg::WGT_W-1:0];
      rd_oob_q <= rd_oob;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rd_vld_q <= 1'b0;
    else         rd_vld_q <= cmd_i.rd_issue;
  end

  // per-channel weighted sums
  assign pix = rd_oob_q ? '0 : rdata_q;

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      if (cmd_i.base_en) acc_q[c] <= '0;
      else if (rd_vld_q)
        acc_q[c] <= acc_q[c] + bis_pkg::ACC_W'(pix[8*c +: 8] * w_q);
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      oor_out_q <= oor_q;
      pix_out_q <= oor_q ? '0 : {acc_q[2][23:16], acc_q[1][23:16], acc_q[0][23:16]};
    end
  end

  assign pixel_out_o    = pix_out_q;
  assign out_of_range_o = oor_out_q;

endmodule

/* verif/bilinear_image_scaler_tb.sv */
// bilinear_image_scaler_tb: self-checking testbench of the bilinear image scaler
// drives load and pixel items, programs the registers over the config port and
// checks every result against a built-in fixed-point blend predictor; needs bis_pkg
module bilinear_image_scaler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH     = bis_pkg::STORE_DEPTH_DEF;
  localparam int unsigned LIMIT     = 600000;
  localparam int unsigned LONG_HOLD = 300;

  typedef struct {
    logic [bis_pkg::PIX_W-1:0] pix;
    logic                      oob;
  } blend_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [bis_pkg::PADDR_W-1:0]  paddr = '0;
  logic [bis_pkg::PDATA_W-1:0]  pwdata = '0;
  logic [bis_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  logic                         req_type_i = bis_pkg::REQ_LOAD;
  logic [bis_pkg::LADDR_W-1:0]  load_address_i = '0;
  logic [bis_pkg::PIXIN_W-1:0]  pixel_value_i = '0;
  logic [bis_pkg::DST_W-1:0]    out_x_i = '0, out_y_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [bis_pkg::PIX_W-1:0]    pixel_out_o;
  logic                         out_of_range_o;

  bilinear_image_scaler dut (.*);

  always #6 clk_i = ~clk_i;

  // shadow of the scaler state
  logic [bis_pkg::PIX_W-1:0]   pix_store [DEPTH];
  bit                          loaded [DEPTH];
  logic [bis_pkg::SRC_W-1:0]   src_w = bis_pkg::SRC_RST, src_h = bis_pkg::SRC_RST;
  logic [bis_pkg::SRC_W-1:0]   src_s = bis_pkg::SRC_RST;
  logic [bis_pkg::DST_W-1:0]   dst_w = bis_pkg::DST_RST, dst_h = bis_pkg::DST_RST;
  logic [bis_pkg::STEP_W-1:0]  x_step = '0, y_step = '0;

  blend_t      pending_pixels [$];
  int unsigned errors = 0, checked = 0, sent = 0, oob_seen = 0, cycles = 0;
  int unsigned burst_left = 0;
  bit          hold_pending = 1'b0;

  function automatic logic [bis_pkg::STEP_W-1:0] scale_step(
      logic [bis_pkg::SRC_W-1:0] src, logic [bis_pkg::DST_W-1:0] dst);
    longint unsigned span, q, d;
    span = (src == 0) ? 64'd0 : 64'(src) - 64'd1;
    d    = (dst == 0) ? 64'd1 : 64'(dst);
    q    = (span << 16) / d;
    return (q > 64'hFFFFFF) ? bis_pkg::STEP_W'(24'hFFFFFF) : bis_pkg::STEP_W'(q);
  endfunction

  function automatic bit off_frame(logic [bis_pkg::DST_W-1:0] x,
                                   logic [bis_pkg::DST_W-1:0] y);
    int unsigned ew, eh;
    ew = (dst_w == 0) ? 1 : 32'(dst_w);
    eh = (dst_h == 0) ? 1 : 32'(dst_h);
    return (32'(x) >= ew) || (32'(y) >= eh);
  endfunction

  // four neighbour addresses: top-left, top-right, lower-left, lower-right
  function automatic void neighbour_addrs(input logic [bis_pkg::DST_W-1:0] x,
                                          input logic [bis_pkg::DST_W-1:0] y,
                                          output longint unsigned a [4],
                                          output int unsigned fx,
                                          output int unsigned fy);
    longint unsigned px, py, base;
    px   = 64'(x_step) * 64'(x);
    py   = 64'(y_step) * 64'(y);
    fx   = 32'((px >> 8) & 64'hFF);
    fy   = 32'((py >> 8) & 64'hFF);
    base = (py >> 16) * 64'(src_s) + (px >> 16);
    a[0] = base;
    a[1] = base + 64'd1;
    a[2] = base + 64'(src_s);
    a[3] = base + 64'(src_s) + 64'd1;
  endfunction

  function automatic blend_t blend_pixel(logic [bis_pkg::DST_W-1:0] x,
                                         logic [bis_pkg::DST_W-1:0] y);
    blend_t                    r;
    longint unsigned           a [4];
    longint unsigned           acc;
    int unsigned               fx, fy;
    int unsigned               w [4];
    logic [bis_pkg::PIX_W-1:0] p [4];
    r.pix = '0;
    r.oob = off_frame(x, y);
    if (r.oob) return r;
    neighbour_addrs(x, y, a, fx, fy);
    foreach (p[i]) p[i] = (a[i] < DEPTH) ? pix_store[a[i]] : '0;
    w[0] = (256 - fx) * (256 - fy);
    w[1] = fx * (256 - fy);
    w[2] = (256 - fx) * fy;
    w[3] = fx * fy;
    for (int sh = 0; sh < 24; sh += 8) begin
      acc = 0;
      foreach (p[i]) acc += 64'((p[i] >> sh) & 24'hFF) * 64'(w[i]);
      r.pix[sh +: 8] = 8'(acc >> 16);
    end
    return r;
  endfunction

  // send one item with burst/gap idling, update the shadow on acceptance
  task automatic send_item(input logic kind, input logic [bis_pkg::LADDR_W-1:0] addr,
                           input logic [bis_pkg::PIXIN_W-1:0] value,
                           input logic [bis_pkg::DST_W-1:0] x,
                           input logic [bis_pkg::DST_W-1:0] y);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= kind;
    load_address_i <= addr;
    pixel_value_i  <= value;
    out_x_i        <= x;
    out_y_i        <= y;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
    if (kind == bis_pkg::REQ_LOAD) begin
      pix_store[addr] = value[bis_pkg::PIX_W-1:0];
      loaded[addr]    = 1'b1;
    end else begin
      pending_pixels.push_back(blend_pixel(x, y));
    end
  endtask

  task automatic load_pixel(input logic [bis_pkg::LADDR_W-1:0] addr);
    send_item(bis_pkg::REQ_LOAD, addr, $urandom, bis_pkg::DST_W'($urandom),
              bis_pkg::DST_W'($urandom));
  endtask

  // a pixel request; first fills any neighbour that was never loaded
  task automatic request_pixel(input logic [bis_pkg::DST_W-1:0] x,
                               input logic [bis_pkg::DST_W-1:0] y);
    longint unsigned a [4];
    int unsigned     fx, fy;
    if (!off_frame(x, y)) begin
      neighbour_addrs(x, y, a, fx, fy);
      foreach (a[i])
        if (a[i] < DEPTH && !loaded[a[i]]) load_pixel(bis_pkg::LADDR_W'(a[i]));
    end
    send_item(bis_pkg::REQ_PIXEL, bis_pkg::LADDR_W'($urandom), $urandom, x, y);
  endtask

  task automatic go_quiet();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // wait for every result, then let a trailing load or divider run settle
  task automatic drain();
    go_quiet();
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(input bis_pkg::reg_idx_e idx,
                           input logic [bis_pkg::PDATA_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= bis_pkg::PADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      bis_pkg::REG_SRC_WIDTH:  src_w = value[bis_pkg::SRC_W-1:0];
      bis_pkg::REG_SRC_HEIGHT: src_h = value[bis_pkg::SRC_W-1:0];
      bis_pkg::REG_SRC_STRIDE: src_s = value[bis_pkg::SRC_W-1:0];
      bis_pkg::REG_DST_WIDTH:  dst_w = value[bis_pkg::DST_W-1:0];
      bis_pkg::REG_DST_HEIGHT: dst_h = value[bis_pkg::DST_W-1:0];
      default: ;
    endcase
    x_step = scale_step(src_w, dst_w);
    y_step = scale_step(src_h, dst_h);
  endtask

  task automatic set_geometry(input int unsigned sw, input int unsigned sh,
                              input int unsigned ss, input int unsigned dw,
                              input int unsigned dh);
    drain();
    write_reg(bis_pkg::REG_SRC_WIDTH, sw);
    write_reg(bis_pkg::REG_SRC_HEIGHT, sh);
    write_reg(bis_pkg::REG_SRC_STRIDE, ss);
    write_reg(bis_pkg::REG_DST_WIDTH, dw);
    write_reg(bis_pkg::REG_DST_HEIGHT, dh);
  endtask

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("%0t mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    blend_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected item", pixel_out_o, 0);
      end else begin
        want = pending_pixels.pop_front();
        checked++;
        if (out_of_range_o) oob_seen++;
        if (pixel_out_o !== want.pix) report_mismatch("pixel_out", pixel_out_o, want.pix);
        if (out_of_range_o !== want.oob)
          report_mismatch("out_of_range", out_of_range_o, want.oob);
      end
    end
  end

  // receiver stall pattern, with one long hold on request
  initial begin
    int unsigned mode, left;
    left = 0;
    mode = 0;
    forever begin
      @(negedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
      end else begin
        if (left == 0) begin
          left = $urandom_range(16, 80);
          mode = $urandom_range(0, 2);
        end
        left--;
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= ($urandom_range(0, 1) == 1);
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // steps are zero after reset, so every in-range pixel blends the store origin
  task automatic test_reset_state();
    request_pixel(12'd0, 12'd0);
    request_pixel(12'd1, 12'd0);
    request_pixel(12'd0, 12'd1);
    request_pixel(12'hFFF, 12'hFFF);
    send_item(bis_pkg::REQ_LOAD, 16'hFFFF, 32'hFFFF_FFFF, 12'hFFF, 12'hFFF);
    send_item(bis_pkg::REQ_LOAD, 16'h0000, 32'h0000_0000, 12'h000, 12'h000);
    request_pixel(12'd0, 12'd0);
  endtask

  // geometry extremes: saturated step, zero source size, zero stride, zero and
  // maximum output size, lower neighbours at the last store addresses
  task automatic test_geometry_edges();
    set_geometry(4, 4, 5, 7, 7);
    request_pixel(12'd0, 12'd0);
    request_pixel(12'd6, 12'd6);
    request_pixel(12'd7, 12'd0);
    set_geometry(511, 511, 16, 0, 1);
    request_pixel(12'd0, 12'd0);
    set_geometry(511, 3, 8, 2, 4095);
    request_pixel(12'd1, 12'd4094);
    request_pixel(12'd1, 12'd4095);
    set_geometry(0, 0, 0, 0, 0);
    request_pixel(12'd0, 12'd0);
    request_pixel(12'd0, 12'd1);
    set_geometry(5, 4, 0, 9, 5);
    request_pixel(12'd8, 12'd4);
    set_geometry(256, 256, 256, 4095, 256);
    request_pixel(12'd4094, 12'd255);
    request_pixel(12'd4095, 12'd0);
    request_pixel(12'd2047, 12'd128);
  endtask

  // random loads and requests until the phase has sent its share of items
  task automatic random_phase(input int unsigned count, input bit hold);
    int unsigned               ew, eh, stop;
    logic [bis_pkg::DST_W-1:0] x, y;
    ew = (dst_w == 0) ? 1 : 32'(dst_w);
    eh = (dst_h == 0) ? 1 : 32'(dst_h);
    stop = sent + count;
    if (hold) hold_pending = 1'b1;
    while (sent < stop) begin
      if ($urandom_range(0, 99) < 12) begin
        load_pixel(bis_pkg::LADDR_W'($urandom));
      end else begin
        if ($urandom_range(0, 99) < 88) begin
          x = bis_pkg::DST_W'($urandom_range(0, ew - 1));
          y = bis_pkg::DST_W'($urandom_range(0, eh - 1));
        end else begin
          x = bis_pkg::DST_W'($urandom);
          y = bis_pkg::DST_W'($urandom);
        end
        request_pixel(x, y);
      end
    end
  endtask

  // mostly small sources, a few large and degenerate ones
  task automatic test_random_scaling();
    int unsigned sw, sh;
    for (int p = 0; p < 8; p++) begin
      sw = $urandom_range(1, 16);
      sh = $urandom_range(1, 16);
      case (p)
        0:       set_geometry(256, 256, 256, 300, 300);
        3:       set_geometry(sw, sh, $urandom_range(0, 511), $urandom_range(0, 4095),
                              $urandom_range(0, 40));
        default: set_geometry(sw, sh, sw + $urandom_range(0, 4), $urandom_range(0, 40),
                              $urandom_range(0, 40));
      endcase
      random_phase(75, p == 2);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_geometry_edges();
    test_random_scaling();
    drain();
    $display("sent %0d items, checked %0d pixel results (%0d out of range)",
             sent, checked, oob_seen);
    $display("covered reset steps, saturated and zero steps, stride extremes and a long stall");
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d errors, %0d results missing", errors, pending_pixels.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
